@@ src/fpa_pkg.sv @@
// shared types, opcodes and defaults for the fixed-point alu
package fpa_pkg;

	// default number of fraction bits (q24.8)
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_GT       = 4'd6,
		OP_LT       = 4'd7,
		OP_GE       = 4'd8,
		OP_LE       = 4'd9,
		OP_EQ       = 4'd10,
		OP_NE       = 4'd11,
		OP_MIN      = 4'd12,
		OP_MAX      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               overflow;
		logic               divide_by_zero;
	} rsp_t;

	// everything but the quotient, carried alongside the divider
	typedef struct packed {
		logic signed [31:0] res;
		logic               cmp;
		logic               ovf;
		logic               is_div;
		logic               neg;
		logic               dz;
	} side_t;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage

@@ src/fpa_div_stage.sv @@
// one restoring-division stage: one quotient bit per beat
module fpa_div_stage #(
	parameter int NW  = 40,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [NW-1:0] n_in,
	input  logic [31:0]   d_in,
	input  logic [31:0]   r_in,
	input  logic [NW-1:0] q_in,
	output logic          vld_s1,
	output logic [NW-1:0] n_s1,
	output logic [31:0]   d_s1,
	output logic [31:0]   r_s1,
	output logic [NW-1:0] q_s1
);

	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {r_in, n_in[NW-1-IDX]};
		diff  = trial - {1'b0, d_in};
		ge    = (trial >= {1'b0, d_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		n_s1 <= n_in;
		d_s1 <= d_in;
		r_s1 <= ge ? diff[31:0] : trial[31:0];
		q_s1 <= {q_in[NW-2:0], ge};
	end

endmodule

@@ src/fpa_divider.sv @@
// pipelined magnitude divider with round half away from zero
module fpa_divider import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  logic [31:0]        mag_a,
	input  logic [31:0]        mag_b,
	output logic               vld_s1,
	output logic [32+FRAC_BITS:0] qmag_s1
);

	localparam int NW = 32 + FRAC_BITS;

	logic          vld [0:NW];
	logic [NW-1:0] n   [0:NW];
	logic [31:0]   d   [0:NW];
	logic [31:0]   r   [0:NW];
	logic [NW-1:0] q   [0:NW];
	logic          rnd;

	// dividend is the magnitude scaled by the fraction
	assign vld[0] = vld_in;
	assign n[0]   = {mag_a, {FRAC_BITS{1'b0}}};
	assign d[0]   = mag_b;
	assign r[0]   = 32'd0;
	assign q[0]   = '0;

	// chain of division stages
	for (genvar i = 0; i < NW; i++) begin : g_stage
		fpa_div_stage #(.NW(NW), .IDX(i)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (vld[i]),
			.n_in   (n[i]),
			.d_in   (d[i]),
			.r_in   (r[i]),
			.q_in   (q[i]),
			.vld_s1 (vld[i+1]),
			.n_s1   (n[i+1]),
			.d_s1   (d[i+1]),
			.r_s1   (r[i+1]),
			.q_s1   (q[i+1])
		);
	end

	// round up when twice the remainder reaches the divisor
	assign rnd = ({r[NW], 1'b0} >= {1'b0, d[NW]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		qmag_s1 <= {1'b0, q[NW]} + (NW+1)'(rnd);
	end

endmodule

@@ src/fpa_simple.sv @@
// two-stage unit for add, sub, inc, dec, mul, compares, min, max and conversions
module fpa_simple import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_in,
	input  cmd_t        cmd,
	input  logic [31:0] mag_a,
	input  logic [31:0] mag_b,
	output logic        vld_s2,
	output side_t       side_s2
);

	localparam int WW = 34 + FRAC_BITS;
	localparam logic signed [WW-1:0] MAXW = WW'(SAT_MAX);
	localparam logic signed [WW-1:0] MINW = WW'(SAT_MIN);
	localparam logic signed [WW-1:0] BIAS = WW'((64'd1 << FRAC_BITS) - 64'd1);

	op_t                op;
	logic signed [31:0] a;
	logic signed [31:0] b;
	logic signed [WW-1:0] aw;
	logic signed [WW-1:0] bw;
	logic signed [WW-1:0] v;
	logic               use_v;
	side_t              side_c;

	logic               vld_s1;
	side_t              side_s1;
	logic               mul_s1;
	logic [63:0]        prod_s1;

	logic [63:0]        m;
	side_t              side_m;

	assign op = op_t'(cmd.opcode);
	assign a  = cmd.operand_a;
	assign b  = cmd.operand_b;
	assign aw = WW'(a);
	assign bw = WW'(b);

	// first stage: wide exact result and compares
	always_comb begin
		v      = '0;
		use_v  = 1'b0;
		side_c = '0;
		side_c.is_div = (op == OP_DIV);
		side_c.neg    = a[31] ^ b[31];
		side_c.dz     = (b == 32'sd0);
		unique case (op)
			OP_ADD: begin
				v = aw + bw;
				use_v = 1'b1;
			end
			OP_SUB: begin
				v = aw - bw;
				use_v = 1'b1;
			end
			OP_INC: begin
				v = aw + WW'(1);
				use_v = 1'b1;
			end
			OP_DEC: begin
				v = aw - WW'(1);
				use_v = 1'b1;
			end
			OP_FROM_INT: begin
				v = aw <<< FRAC_BITS;
				use_v = 1'b1;
			end
			OP_TO_INT: begin
				v = (aw + (a[31] ? BIAS : WW'(0))) >>> FRAC_BITS;
				use_v = 1'b1;
			end
			OP_GT:  side_c.cmp = (a > b);
			OP_LT:  side_c.cmp = (a < b);
			OP_GE:  side_c.cmp = (a >= b);
			OP_LE:  side_c.cmp = (a <= b);
			OP_EQ:  side_c.cmp = (a == b);
			OP_NE:  side_c.cmp = (a != b);
			OP_MIN: side_c.res = (a < b) ? a : b;
			OP_MAX: side_c.res = (a > b) ? a : b;
			OP_MUL, OP_DIV: ;
			default: ;
		endcase
		// saturate the wide result
		if (use_v) begin
			if (v > MAXW) begin
				side_c.res = SAT_MAX;
				side_c.ovf = 1'b1;
			end else if (v < MINW) begin
				side_c.res = SAT_MIN;
				side_c.ovf = 1'b1;
			end else begin
				side_c.res = v[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		mul_s1  <= (op == OP_MUL);
		prod_s1 <= mag_a * mag_b;
	end

	// second stage: drop fraction bits of the product with rounding
	if (FRAC_BITS > 0) begin : g_rnd
		assign m = (prod_s1 >> FRAC_BITS) + 64'(prod_s1[FRAC_BITS-1]);
	end else begin : g_nornd
		assign m = prod_s1;
	end

	// sign and saturation of the rounded product
	always_comb begin
		side_m = side_s1;
		if (mul_s1) begin
			side_m.ovf = 1'b0;
			if (side_s1.neg) begin
				if (m > 64'h8000_0000) begin
					side_m.res = SAT_MIN;
					side_m.ovf = 1'b1;
				end else begin
					side_m.res = ~m[31:0] + 32'd1;
				end
			end else begin
				if (m > 64'h7fff_ffff) begin
					side_m.res = SAT_MAX;
					side_m.ovf = 1'b1;
				end else begin
					side_m.res = m[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_m;
	end

endmodule

@@ src/fixed_point_alu.sv @@
// signed fixed-point alu: top level with input stage, alignment and output stage
// every opcode passes the same depth: the short path is delayed to match the divider
// throughput: one command per cycle; busy is never raised
// the pipelined divider (one quotient bit per stage) sets the depth
// results appear for one cycle with done high; the receiver cannot stall
// reset clears only the valid bits; in-flight commands are dropped
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int NW  = 32 + FRAC_BITS;
	localparam int DLY = NW - 1;
	localparam logic [NW:0] LIM_NEG = (NW+1)'(64'h8000_0000);
	localparam logic [NW:0] LIM_POS = (NW+1)'(64'h7fff_ffff);

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic [31:0] ua;
	logic [31:0] ub;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	logic        simp_vld;
	side_t       simp_side;
	logic        div_vld;
	logic [NW:0] qmag;

	logic        dly_vld_q  [0:DLY];
	side_t       dly_side_q [0:DLY];
	side_t       side_al;
	rsp_t        rsp_c;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// operand magnitudes
	always_comb begin
		ua    = cmd_s1.operand_a;
		ub    = cmd_s1.operand_b;
		mag_a = ua[31] ? (~ua + 32'd1) : ua;
		mag_b = ub[31] ? (~ub + 32'd1) : ub;
	end

	fpa_simple #(.FRAC_BITS(FRAC_BITS)) u_simple (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.cmd     (cmd_s1),
		.mag_a   (mag_a),
		.mag_b   (mag_b),
		.vld_s2  (simp_vld),
		.side_s2 (simp_side)
	);

	fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.mag_a   (mag_a),
		.mag_b   (mag_b),
		.vld_s1  (div_vld),
		.qmag_s1 (qmag)
	);

	// delay line that lines the short path up with the divider
	assign dly_vld_q[0]  = simp_vld;
	assign dly_side_q[0] = simp_side;

	for (genvar i = 1; i <= DLY; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_vld_q[i] <= 1'b0;
			end else begin
				dly_vld_q[i] <= dly_vld_q[i-1];
			end
		end

		always_ff @(posedge clk) begin
			dly_side_q[i] <= dly_side_q[i-1];
		end
	end

	assign side_al = dly_side_q[DLY];

	// final select, sign and saturation of the quotient
	always_comb begin
		rsp_c.result_value   = side_al.res;
		rsp_c.compare_true   = side_al.cmp;
		rsp_c.overflow       = side_al.ovf;
		rsp_c.divide_by_zero = 1'b0;
		if (side_al.is_div) begin
			rsp_c.overflow = 1'b0;
			if (side_al.dz) begin
				rsp_c.result_value   = 32'sd0;
				rsp_c.divide_by_zero = 1'b1;
			end else if (side_al.neg) begin
				if (qmag > LIM_NEG) begin
					rsp_c.result_value = SAT_MIN;
					rsp_c.overflow     = 1'b1;
				end else begin
					rsp_c.result_value = ~qmag[31:0] + 32'd1;
				end
			end else begin
				if (qmag > LIM_POS) begin
					rsp_c.result_value = SAT_MAX;
					rsp_c.overflow     = 1'b1;
				end else begin
					rsp_c.result_value = qmag[31:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld & dly_vld_q[DLY];
		end
	end

	always_ff @(posedge clk) begin
		rsp <= rsp_c;
	end

endmodule

@@ tb/fixed_point_alu_tb.sv @@
// self-checking testbench for the signed q24.8 fixed-point alu
module fixed_point_alu_tb import fpa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 35;
	localparam int N_RANDOM = 1200;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;

	rsp_t expected_q[$];
	int errors;
	int beats_in;
	int beats_out;
	longint cycles;

	// directed row: command plus optional hand-typed result
	typedef struct {
		op_t opcode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit typed;
		rsp_t want;
	} row_t;

	fixed_point_alu #(.FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// saturate a wide value to 32 bits
	function automatic void clamp32(input logic signed [65:0] v,
			output logic signed [31:0] r, output logic o);
		if (v > 66'sd2147483647) begin
			r = SAT_MAX;
			o = 1'b1;
		end else if (v < -66'sd2147483648) begin
			r = SAT_MIN;
			o = 1'b1;
		end else begin
			r = v[31:0];
			o = 1'b0;
		end
	endfunction

	// magnitude quotient rounded half away from zero
	function automatic logic [65:0] round_quot(input logic [65:0] n, input logic [65:0] d);
		logic [65:0] q;
		logic [65:0] r;
		q = n / d;
		r = n % d;
		if (2 * r >= d)
			q = q + 1;
		return q;
	endfunction

	// exact alu behaviour
	function automatic rsp_t alu_result(input cmd_t c);
		rsp_t r;
		logic signed [65:0] a;
		logic signed [65:0] b;
		logic signed [65:0] w;
		logic [65:0] ma;
		logic [65:0] mb;
		logic [65:0] m;
		logic neg;
		r = '0;
		a = c.operand_a;
		b = c.operand_b;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		case (op_t'(c.opcode))
			OP_ADD: clamp32(a + b, r.result_value, r.overflow);
			OP_SUB: clamp32(a - b, r.result_value, r.overflow);
			OP_MUL: begin
				m = round_quot(ma * mb, 66'd1 << FB);
				w = neg ? -$signed(m) : $signed(m);
				clamp32(w, r.result_value, r.overflow);
			end
			OP_DIV: begin
				if (b == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					m = round_quot(ma << FB, mb);
					w = neg ? -$signed(m) : $signed(m);
					clamp32(w, r.result_value, r.overflow);
				end
			end
			OP_INC: clamp32(a + 1, r.result_value, r.overflow);
			OP_DEC: clamp32(a - 1, r.result_value, r.overflow);
			OP_GT: r.compare_true = a > b;
			OP_LT: r.compare_true = a < b;
			OP_GE: r.compare_true = a >= b;
			OP_LE: r.compare_true = a <= b;
			OP_EQ: r.compare_true = a == b;
			OP_NE: r.compare_true = a != b;
			OP_MIN: r.result_value = a < b ? c.operand_a : c.operand_b;
			OP_MAX: r.result_value = a > b ? c.operand_a : c.operand_b;
			OP_TO_INT: begin
				m = ma >> FB;
				w = a < 0 ? -$signed(m) : $signed(m);
				r.result_value = w[31:0];
			end
			default: clamp32(a * (66'sd1 <<< FB), r.result_value, r.overflow);
		endcase
		return r;
	endfunction

	// send one beat after a random gap
	task automatic send_beat(input cmd_t c, input bit typed, input rsp_t want);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_q.push_back(typed ? want : alu_result(c));
		beats_in++;
	endtask

	// operand with bias toward edge values
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff - $urandom_range(0, 2);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 3) << FB;
			3: return -($urandom_range(0, 600));
			4: return $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	// result checking
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			beats_out++;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (rsp.result_value !== e.result_value) begin
					$error("result_value expected %0d actual %0d", e.result_value,
						rsp.result_value);
					errors++;
				end
				if (rsp.compare_true !== e.compare_true) begin
					$error("compare_true expected %0b actual %0b", e.compare_true,
						rsp.compare_true);
					errors++;
				end
				if (rsp.overflow !== e.overflow) begin
					$error("overflow expected %0b actual %0b", e.overflow, rsp.overflow);
					errors++;
				end
				if (rsp.divide_by_zero !== e.divide_by_zero) begin
					$error("divide_by_zero expected %0b actual %0b", e.divide_by_zero,
						rsp.divide_by_zero);
					errors++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("fixed_point_alu_tb failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t rows[$];
		row_t rw;
		cmd_t c;
		int wait_cycles;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: extremes, every opcode, special cases
		rows = '{
			'{OP_ADD, 32'sh7fff_ffff, 32'sd1, 1, '{SAT_MAX, 0, 1, 0}},
			'{OP_ADD, 32'sh8000_0000, -32'sd1, 1, '{SAT_MIN, 0, 1, 0}},
			'{OP_SUB, 32'sh8000_0000, 32'sd1, 1, '{SAT_MIN, 0, 1, 0}},
			'{OP_SUB, 32'sd0, 32'sh8000_0000, 1, '{SAT_MAX, 0, 1, 0}},
			'{OP_MUL, 32'sd384, 32'sd384, 0, '0},
			'{OP_MUL, -32'sd1, 32'sd128, 0, '0},
			'{OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1, '{SAT_MAX, 0, 1, 0}},
			'{OP_MUL, 32'sh7fff_ffff, 32'sh8000_0000, 1, '{SAT_MIN, 0, 1, 0}},
			'{OP_DIV, 32'sd256, 32'sd0, 1, '{32'sd0, 0, 0, 1}},
			'{OP_DIV, 32'sd256, 32'sd768, 0, '0},
			'{OP_DIV, 32'sh8000_0000, 32'sd1, 1, '{SAT_MIN, 0, 1, 0}},
			'{OP_DIV, -32'sd640, 32'sd512, 0, '0},
			'{OP_INC, 32'sh7fff_ffff, 32'sd0, 1, '{SAT_MAX, 0, 1, 0}},
			'{OP_DEC, 32'sh8000_0000, 32'sd0, 1, '{SAT_MIN, 0, 1, 0}},
			'{OP_GT, 32'sd5, 32'sd5, 1, '{32'sd0, 0, 0, 0}},
			'{OP_LT, 32'sh8000_0000, 32'sh7fff_ffff, 1, '{32'sd0, 1, 0, 0}},
			'{OP_GE, 32'sd5, 32'sd5, 1, '{32'sd0, 1, 0, 0}},
			'{OP_LE, 32'sd6, 32'sd5, 1, '{32'sd0, 0, 0, 0}},
			'{OP_EQ, -32'sd1, -32'sd1, 1, '{32'sd0, 1, 0, 0}},
			'{OP_NE, -32'sd1, -32'sd1, 1, '{32'sd0, 0, 0, 0}},
			'{OP_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1, '{SAT_MIN, 0, 0, 0}},
			'{OP_MAX, 32'sd7, 32'sd7, 1, '{32'sd7, 0, 0, 0}},
			'{OP_TO_INT, -32'sd257, 32'sd0, 1, '{-32'sd1, 0, 0, 0}},
			'{OP_TO_INT, 32'sh7fff_ffff, 32'sd0, 0, '0},
			'{OP_FROM_INT, 32'sh0080_0000, 32'sd0, 1, '{SAT_MAX, 0, 1, 0}}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			c.opcode = rw.opcode;
			c.operand_a = rw.a;
			c.operand_b = rw.b;
			send_beat(c, rw.typed, rw.want);
		end

		// random part, with one pause until the pipe drains
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				while (expected_q.size() != 0)
					@(posedge clk);
			end
			c.opcode = 4'($urandom_range(0, 15));
			c.operand_a = pick_operand();
			c.operand_b = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_operand();
			send_beat(c, 0, '0);
		end
		start <= 1'b0;

		// drain
		wait_cycles = 0;
		while (expected_q.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			errors++;
		end
		$display("covered %0d command beats over all 16 opcodes, %0d results checked",
			beats_in, beats_out);
		if (errors == 0)
			$display("fixed_point_alu_tb passed");
		else
			$display("fixed_point_alu_tb failed");
		$finish;
	end
endmodule
